/* design/psq_pkg.sv */
// shared types and constants for the prime sieve query block
// no dependencies; used by the interfaces, the sequencer, the bitmap and the top level
`default_nettype none

package psq_pkg;

   // fixed field widths of the request and response
   localparam int LIMIT_W = 12;
   localparam int INDEX_W = 6;
   localparam int WORD_W  = 64;
   localparam int WORD_SH = 6;
   localparam int LIMIT_MAX = 4095;

   // base counter holds up to 64, numbers up to limit plus one base
   localparam int BASE_W = 7;
   localparam int SQ_W   = 2 * BASE_W;
   localparam int NUM_W  = LIMIT_W + 1;

   // bitmap command from the sequencer, address travels beside it
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              wr_value;
      logic [WORD_W-1:0] bit_mask;
   } mem_cmd_type;

   // one finished response word
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  prime_mask;
      logic               last_word;
   } emit_type;

endpackage

`default_nettype wire

/* design/psq_if.sv */
// request and response channel interfaces of the prime sieve query block
// depends on psq_pkg for the field widths
`default_nettype none

interface psq_req_if;
   logic                          valid;
   logic                          ready;
   logic [psq_pkg::LIMIT_W-1:0]   query_limit;

   modport source (output valid, output query_limit, input ready);
   modport sink   (input valid, input query_limit, output ready);
endinterface

interface psq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psq_pkg::INDEX_W-1:0]   word_index;
   logic [psq_pkg::WORD_W-1:0]    prime_mask;
   logic                          last_word;

   modport source (output valid, output word_index, output prime_mask, output last_word,
                   input ready);
   modport sink   (input valid, input word_index, input prime_mask, input last_word,
                   output ready);
endinterface

`default_nettype wire

/* design/prime_sieve_query.sv */
// Sieve of Eratosthenes with a retained primality bitmap. Each request carries
// an upper limit (saturated to SIEVE_SIZE-1); the response is limit/64+1 words of
// 64 flags, bit b of word w set when 64*w+b is prime, the last word marked. A
// request whose limit is within what has already been sieved only reads the
// bitmap out, one read step and one emit step per word; each word waits in
// the emit step until the output register is free. A request above the sieved
// limit first refills words 0 to limit/64 and re-sieves: a read, a check and an
// increment per base up to the square root of the limit, and one strike write
// per struck multiple, before the readout starts. The bitmap memory is
// single-port, one access per cycle. The block takes one request at a time; a
// finished word waits in an output register while the next is read.
// depends on psq_pkg, psq_if, psq_ctrl and psq_bitmap
`default_nettype none

module prime_sieve_query #(
   parameter int SIEVE_SIZE = 4096
) (
   input  wire logic  clock,
   input  wire logic  reset,
   psq_req_if.sink    req_chan,
   psq_rsp_if.source  rsp_chan
);

   localparam int WordCount = SIEVE_SIZE / 64;
   localparam int WordAw    = (WordCount > 1) ? $clog2(WordCount) : 1;

   psq_pkg::emit_type                 emit;
   psq_pkg::mem_cmd_type              mem_cmd;
   logic [WordAw-1:0]                 mem_addr;
   logic [psq_pkg::WORD_W-1:0]        rd_data;
   logic                              out_free;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [psq_pkg::INDEX_W-1:0]       rsp_index_ff;
   logic [psq_pkg::WORD_W-1:0]        rsp_mask_ff;
   logic                              rsp_last_ff;

   psq_ctrl #(
      .SIEVE_SIZE (SIEVE_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_limit (req_chan.query_limit),
      .req_ready (req_chan.ready),
      .out_free  (out_free),
      .emit      (emit),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .rd_data   (rd_data)
   );

   psq_bitmap #(
      .SIEVE_SIZE (SIEVE_SIZE)
   ) u_bitmap (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .rd_data (rd_data)
   );

   // output register frees when empty or being taken
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = emit.valid || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit.valid) begin
         rsp_index_ff <= emit.word_index;
         rsp_mask_ff  <= emit.prime_mask;
         rsp_last_ff  <= emit.last_word;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.word_index = rsp_index_ff;
   assign rsp_chan.prime_mask = rsp_mask_ff;
   assign rsp_chan.last_word  = rsp_last_ff;

endmodule

`default_nettype wire

/* design/psq_bitmap.sv */
// primality bitmap: 64-bit words with per-bit write enables, registered read
// depends on psq_pkg for the command struct
`default_nettype none

module psq_bitmap #(
   parameter int SIEVE_SIZE = 4096
) (
   input  wire logic                                    clock,
   input  wire psq_pkg::mem_cmd_type                    cmd,
   input  wire logic [((SIEVE_SIZE/64 > 1) ? $clog2(SIEVE_SIZE/64) : 1)-1:0] addr,
   output logic [psq_pkg::WORD_W-1:0]                   rd_data
);

   localparam int WordCount = SIEVE_SIZE / 64;
   localparam int WordW     = psq_pkg::WORD_W;

   logic [WordW-1:0] mem_ff [WordCount];
   logic [WordW-1:0] rd_data_ff;

   // bit-masked write
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         for (int i = 0; i < WordW; i++) begin
            if (cmd.bit_mask[i]) begin
               mem_ff[addr][i] <= cmd.wr_value;
            end
         end
      end
   end

   // registered read, held between reads
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/psq_ctrl.sv */
// sieve sequencer: fill, base scan, strike and word readout around one shared adder
// depends on psq_pkg; drives psq_bitmap
`default_nettype none

module psq_ctrl #(
   parameter int SIEVE_SIZE = 4096
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   input  wire logic [psq_pkg::LIMIT_W-1:0]             req_limit,
   output logic                                         req_ready,
   input  wire logic                                    out_free,
   output psq_pkg::emit_type                            emit,
   output psq_pkg::mem_cmd_type                         mem_cmd,
   output logic [((SIEVE_SIZE/64 > 1) ? $clog2(SIEVE_SIZE/64) : 1)-1:0] mem_addr,
   input  wire logic [psq_pkg::WORD_W-1:0]              rd_data
);

   localparam int WordCount = SIEVE_SIZE / 64;
   localparam int WordAw    = (WordCount > 1) ? $clog2(WordCount) : 1;
   localparam int LimW      = psq_pkg::LIMIT_W;
   localparam int NumW      = psq_pkg::NUM_W;
   localparam int BaseW     = psq_pkg::BASE_W;
   localparam int SqW       = psq_pkg::SQ_W;
   localparam int WordW     = psq_pkg::WORD_W;
   localparam int IdxW      = psq_pkg::INDEX_W;
   localparam int WordSh    = psq_pkg::WORD_SH;
   localparam int MaxLimitInt =
      (SIEVE_SIZE - 1 < psq_pkg::LIMIT_MAX) ? SIEVE_SIZE - 1 : psq_pkg::LIMIT_MAX;
   localparam logic [LimW-1:0] MaxLimit = LimW'(MaxLimitInt);

   typedef enum logic [2:0] {
      IDLE,
      FILL,
      BASE_RD,
      BASE_CHK,
      BASE_INC,
      STRIKE,
      EMIT_RD,
      EMIT_WAIT
   } state_type;

   state_type          state_ff, state_in;
   logic [LimW-1:0]    lim_ff, lim_in;
   logic [LimW-1:0]    sieved_ff, sieved_in;
   logic [BaseW-1:0]   base_ff, base_in;
   logic [SqW-1:0]     sq_ff, sq_in;
   logic [NumW-1:0]    num_ff, num_in;
   logic [WordAw-1:0]  widx_ff, widx_in;

   logic [LimW-1:0]    sat_limit;
   logic [WordAw-1:0]  lim_word;
   logic [NumW-1:0]    add_a, add_b, add_sum;
   logic [WordW-1:0]   keep_mask;
   logic               last;

   // saturate the request limit to the store
   assign sat_limit = (req_limit > MaxLimit) ? MaxLimit : req_limit;
   assign lim_word  = WordAw'(lim_ff >> WordSh);
   assign last      = (widx_ff == lim_word);

   // shared adder: strike step, base increment or word counter
   always_comb begin
      case (state_ff)
         STRIKE: begin
            add_a = num_ff;
            add_b = NumW'(base_ff);
         end
         BASE_INC: begin
            add_a = NumW'(base_ff);
            add_b = NumW'(1);
         end
         default: begin
            add_a = NumW'(widx_ff);
            add_b = NumW'(1);
         end
      endcase
   end
   assign add_sum = add_a + add_b;

   // bits kept in the word being read out: within the limit, not 0 or 1
   always_comb begin
      keep_mask = '1;
      if (last) begin
         keep_mask = (WordW'(2) << lim_ff[WordSh-1:0]) - WordW'(1);
      end
      if (widx_ff == '0) begin
         keep_mask = keep_mask & ~WordW'(3);
      end
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      lim_in    = lim_ff;
      sieved_in = sieved_ff;
      base_in   = base_ff;
      sq_in     = sq_ff;
      num_in    = num_ff;
      widx_in   = widx_ff;
      req_ready = 1'b0;
      mem_cmd   = '0;
      mem_addr  = widx_ff;
      emit      = '0;
      emit.word_index = IdxW'(widx_ff);
      emit.prime_mask = rd_data & keep_mask;
      emit.last_word  = last;

      unique case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               lim_in  = sat_limit;
               widx_in = '0;
               if (sat_limit > sieved_ff) begin
                  sieved_in = sat_limit;
                  state_in  = FILL;
               end else begin
                  state_in = EMIT_RD;
               end
            end
         end
         FILL: begin
            mem_cmd.wr_en    = 1'b1;
            mem_cmd.wr_value = 1'b1;
            mem_cmd.bit_mask = '1;
            if (last) begin
               base_in  = BaseW'(2);
               state_in = BASE_RD;
            end else begin
               widx_in = WordAw'(add_sum);
            end
         end
         BASE_RD: begin
            mem_cmd.rd_en = 1'b1;
            mem_addr      = WordAw'(base_ff >> WordSh);
            sq_in         = SqW'(base_ff * base_ff);
            state_in      = BASE_CHK;
         end
         BASE_CHK: begin
            if (sq_ff > SqW'(lim_ff)) begin
               widx_in  = '0;
               state_in = EMIT_RD;
            end else if (rd_data[base_ff[WordSh-1:0]]) begin
               num_in   = NumW'(sq_ff);
               state_in = STRIKE;
            end else begin
               state_in = BASE_INC;
            end
         end
         BASE_INC: begin
            base_in  = BaseW'(add_sum);
            state_in = BASE_RD;
         end
         STRIKE: begin
            mem_cmd.wr_en    = 1'b1;
            mem_cmd.wr_value = 1'b0;
            mem_cmd.bit_mask = WordW'(1) << num_ff[WordSh-1:0];
            mem_addr         = WordAw'(num_ff >> WordSh);
            num_in           = add_sum;
            if (add_sum > NumW'(lim_ff)) begin
               state_in = BASE_INC;
            end
         end
         EMIT_RD: begin
            mem_cmd.rd_en = 1'b1;
            state_in      = EMIT_WAIT;
         end
         EMIT_WAIT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               if (last) begin
                  state_in = IDLE;
               end else begin
                  widx_in  = WordAw'(add_sum);
                  state_in = EMIT_RD;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         sieved_ff <= '0;
      end else begin
         state_ff  <= state_in;
         sieved_ff <= sieved_in;
      end
      lim_ff  <= lim_in;
      base_ff <= base_in;
      sq_ff   <= sq_in;
      num_ff  <= num_in;
      widx_ff <= widx_in;
   end

endmodule

`default_nettype wire

/* tb/psq_sieve_checker.sv */
`timescale 1ns / 100ps
// response checker for the prime sieve query block: keeps its own sieve bitmap,
// predicts the words of every accepted request and compares each response word
// depends on psq_pkg and the psq_req_if / psq_rsp_if interfaces

module psq_sieve_checker
   import psq_pkg::*;
#(
   parameter int SIEVE_SIZE = 4096
) (
   input  logic clock,
   input  logic reset,
   psq_req_if   req_mon,
   psq_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   words_pending
);

   typedef struct packed {
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  prime_mask;
      logic               last_word;
   } sieve_word_t;

   // predicted primality bitmap and how far it has been sieved
   bit          sieve_flags [0:SIEVE_SIZE-1];
   int          sieved_to;
   sieve_word_t expected_words [$];
   int          fails;

   // refill 0..lim and strike out multiples of every remaining base
   function automatic void resieve(input int lim);
      int b, m;
      for (m = 0; m <= lim; m++)
         sieve_flags[m] = 1'b1;
      for (b = 2; b * b <= lim; b++) begin
         if (sieve_flags[b]) begin
            for (m = b * b; m <= lim; m += b)
               sieve_flags[m] = 1'b0;
         end
      end
   endfunction

   // expected words for one request, queued in emission order
   function automatic void predict_query(input logic [LIMIT_W-1:0] query_limit);
      int          lim, nwords, w, k, num;
      sieve_word_t word;
      lim = query_limit;
      if (lim > SIEVE_SIZE - 1)
         lim = SIEVE_SIZE - 1;
      if (lim > sieved_to) begin
         resieve(lim);
         sieved_to = lim;
      end
      nwords = lim / 64 + 1;
      for (w = 0; w < nwords; w++) begin
         word.word_index = w[INDEX_W-1:0];
         word.prime_mask = '0;
         for (k = 0; k < 64; k++) begin
            num = w * 64 + k;
            if (num >= 2 && num <= lim && sieve_flags[num])
               word.prime_mask[k] = 1'b1;
         end
         word.last_word = (w + 1 == nwords);
         expected_words.push_back(word);
      end
   endfunction

   // watch both channels at the rising edge
   always @(posedge clock) begin
      sieve_word_t want;
      if (reset) begin
         expected_words.delete();
         sieved_to = 0;
         fails = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_query(req_mon.query_limit);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual index %0d mask %h last %b",
                        $time, rsp_mon.word_index, rsp_mon.prime_mask, rsp_mon.last_word);
               fails++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.word_index !== want.word_index) begin
                  $display("%0t: word_index expected %0d actual %0d",
                           $time, want.word_index, rsp_mon.word_index);
                  fails++;
               end
               if (rsp_mon.prime_mask !== want.prime_mask) begin
                  $display("%0t: prime_mask of word %0d expected %h actual %h",
                           $time, want.word_index, want.prime_mask, rsp_mon.prime_mask);
                  fails++;
               end
               if (rsp_mon.last_word !== want.last_word) begin
                  $display("%0t: last_word of word %0d expected %b actual %b",
                           $time, want.word_index, want.last_word, rsp_mon.last_word);
                  fails++;
               end
            end
         end
      end
      mismatch_count <= fails;
      words_pending  <= expected_words.size();
   end

endmodule

/* tb/tb_prime_sieve_query.sv */
`timescale 1ns / 100ps
// testbench top for the prime sieve query block: drives directed and random
// limit requests with random gaps and back-pressure, gives the verdict
// depends on psq_pkg, psq_if, prime_sieve_query and psq_sieve_checker

module tb_prime_sieve_query;
   import psq_pkg::*;

   localparam int SIEVE_DEPTH = 4096;
   localparam int N_RANDOM    = 76;
   localparam int IDLE_LIMIT  = 40000;
   localparam int DRAIN_WAIT  = 200;

   logic clock = 1'b0;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   quiet_cycles;
   int   mismatch_count;
   int   words_pending;

   psq_req_if req_chan ();
   psq_rsp_if rsp_chan ();

   prime_sieve_query #(
      .SIEVE_SIZE(SIEVE_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   psq_sieve_checker #(
      .SIEVE_SIZE(SIEVE_DEPTH)
   ) word_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[prime_sieve_query] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      logic [LIMIT_W-1:0] plan [$];
      int top_limit, pick, lim, k, n;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.query_limit = '0;
      rsp_chan.ready       = 1'b0;
      req_idle_pct         = 17;
      rsp_idle_pct         = 61;
      quiet_cycles         = 0;

      // directed: first a limit of one (sieves word 0), then limit zero, tiny
      // sieves, squares of primes, word boundaries, reads within the sieved range
      plan = '{12'd1, 12'd0, 12'd2, 12'd3, 12'd1, 12'd4, 12'd25, 12'd24, 12'd49,
               12'd63, 12'd64, 12'd65, 12'd62, 12'd127, 12'd128, 12'd0, 12'd1000,
               12'd1023, 12'd1024, 12'd999};
      top_limit = 1024;

      // random: mostly reads of the sieved range, some growing re-sieves
      for (n = 0; n < N_RANDOM; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3 && top_limit < LIMIT_MAX) begin
            lim = top_limit + int'($urandom_range(1, 200));
         end else if (pick < 5) begin
            k   = $urandom_range(0, top_limit / 64);
            lim = k * 64 + int'($urandom_range(0, 2)) - 1;
         end else begin
            lim = $urandom_range(0, top_limit);
         end
         if (lim < 0)
            lim = 0;
         if (lim > LIMIT_MAX)
            lim = LIMIT_MAX;
         if (lim > top_limit)
            top_limit = lim;
         plan.push_back(lim[LIMIT_W-1:0]);
      end

      // full store, just below it, a lone top bit, zero again
      plan.push_back(LIMIT_W'(LIMIT_MAX));
      plan.push_back(12'd4094);
      plan.push_back(12'd2048);
      plan.push_back(12'd0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // three idling phases over the request list
      for (n = 0; n < plan.size(); n++) begin
         if (n < plan.size() / 3) begin
            req_idle_pct = 17;
            rsp_idle_pct = 61;
         end else if (n < 2 * plan.size() / 3) begin
            req_idle_pct = 61;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         @(negedge clock);
         while ($urandom_range(0, 99) < req_idle_pct) begin
            req_chan.valid       <= 1'b0;
            req_chan.query_limit <= LIMIT_W'($urandom);
            @(negedge clock);
         end
         req_chan.valid       <= 1'b1;
         req_chan.query_limit <= plan[n];
         @(posedge clock);
         while (!req_chan.ready)
            @(posedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // drain outstanding words, then watch for strays
      while (words_pending != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[prime_sieve_query] OK");
      end else begin
         $display("[prime_sieve_query] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
design/psq_pkg.sv
design/psq_if.sv
design/psq_bitmap.sv
design/psq_ctrl.sv
design/prime_sieve_query.sv
tb/psq_sieve_checker.sv
tb/tb_prime_sieve_query.sv
